@@ rtl/core/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies; the including module provides clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// implication from a trigger to a property in the next cycle
`define ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/core/fcpg_pkg.sv @@
// package for the framed counter pattern generator: sizes, codes, write structs
// and the byte formatting function; no dependencies
package fcpg_pkg;

  localparam int MAX_FIELDS   = 8;
  localparam int MAX_CHANNELS = 16;

  localparam int FIELD_IDX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int CHAN_IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FIELD_CNT_W = $clog2(MAX_FIELDS + 1);
  localparam int CHAN_CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int IDX_W       = (FIELD_CNT_W > CHAN_CNT_W) ? FIELD_CNT_W : CHAN_CNT_W;
  localparam int LEN_W       = $clog2(MAX_CHANNELS * 8 + MAX_FIELDS * 8 + 1);

  typedef enum logic [1:0] {
    OP_LOAD_FIELD = 2'd0,
    OP_LOAD_CHAN  = 2'd1,
    OP_EMIT       = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_FIXED = 2'd1,
    KIND_SIZE  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CFG_WORD_SIZE  = 3'd0,
    CFG_COUNT_DOWN = 3'd1,
    CFG_BIG_ENDIAN = 3'd2,
    CFG_STEP       = 3'd3,
    CFG_CHAN_COUNT = 3'd4,
    CFG_HDR_COUNT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                   en;
    logic [FIELD_IDX_W-1:0] idx;
    logic [3:0]             len;
    logic [1:0]             kind;
    logic [63:0]            value;
  } hdr_wr_t;

  typedef struct packed {
    logic                  en;
    logic [CHAN_IDX_W-1:0] idx;
    logic [63:0]           data;
  } chan_wr_t;

  // keep the low n bytes, then reverse them for big endian 2, 4 and 8 byte words
  function automatic logic [63:0] format_bytes(input logic [63:0] v, input logic [3:0] n,
                                               input logic big);
    logic [63:0] kept;
    logic [63:0] rev;
    logic [3:0]  src;
    logic        swap;
    kept = '0;
    rev  = '0;
    src  = '0;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < n) begin
        kept[8*j +: 8] = v[8*j +: 8];
      end
    end
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < n) begin
        src = n - 4'(j) - 4'd1;
        rev[8*j +: 8] = kept[{src[2:0], 3'b000} +: 8];
      end
    end
    swap = big && (n == 4'd2 || n == 4'd4 || n == 4'd8);
    return swap ? rev : kept;
  endfunction

endpackage

@@ rtl/core/fcpg_hdr_table.sv @@
// header field table: length, kind and fixed value per field, one read port
// depends on fcpg_pkg
module fcpg_hdr_table (
  input  logic                            clk_i,
  input  fcpg_pkg::hdr_wr_t               wr_i,
  input  logic [fcpg_pkg::FIELD_IDX_W-1:0] rd_idx_i,
  output logic [3:0]                      rd_len_o,
  output logic [1:0]                      rd_kind_o,
  output logic [63:0]                     rd_value_o
);

  logic [3:0]  len_q   [fcpg_pkg::MAX_FIELDS];
  logic [1:0]  kind_q  [fcpg_pkg::MAX_FIELDS];
  logic [63:0] value_q [fcpg_pkg::MAX_FIELDS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      len_q[wr_i.idx]   <= wr_i.len;
      kind_q[wr_i.idx]  <= wr_i.kind;
      value_q[wr_i.idx] <= wr_i.value;
    end
  end

  assign rd_len_o   = len_q[rd_idx_i];
  assign rd_kind_o  = kind_q[rd_idx_i];
  assign rd_value_o = value_q[rd_idx_i];

endmodule

@@ rtl/core/fcpg_chan_bank.sv @@
// channel counter bank with per-entry valid bits; unwritten entries read as zero
// depends on fcpg_pkg
module fcpg_chan_bank (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fcpg_pkg::chan_wr_t             wr_i,
  input  logic [fcpg_pkg::CHAN_IDX_W-1:0] rd_idx_i,
  output logic [63:0]                    rd_data_o
);

  logic [63:0]                       cnt_q [fcpg_pkg::MAX_CHANNELS];
  logic [fcpg_pkg::MAX_CHANNELS-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      cnt_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_data_o = vld_q[rd_idx_i] ? cnt_q[rd_idx_i] : 64'd0;

endmodule

@@ rtl/core/fcpg_alu.sv @@
// shared 64-bit add/subtract unit: frame length sum and counter stepping
// no dependencies
module fcpg_alu (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        sub_i,
  output logic [63:0] sum_o
);

  assign sum_o = a_i + (b_i ^ {64{sub_i}}) + 64'(sub_i);

endmodule

@@ rtl/core/framed_counter_pattern_generator.sv @@
// framed counter pattern generator top level: sequencer, config registers, output stage
// depends on fcpg_pkg, fcpg_hdr_table, fcpg_chan_bank, fcpg_alu, assert_macros.svh
//
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_ready_o   operation, slot, field_bytes, kind, value
//  out       source     out_valid_o / out_ready_i bytes, count, end_of_frame
//  cfg       sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// a load leaves the sequencer idle; an emit (nf header fields, nc channels) runs a pass
// of the shared adder that sums the field lengths, then one result per cycle while out
// is not stalled, the adder stepping each counter as it goes out
// in_ready_o is high only while the sequencer is idle; out stalls hold the sequencer
// reset is asynchronous active low; counters read as zero until first written, no clearing pass
`include "assert_macros.svh"

module framed_counter_pattern_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_operation_i,
  input  logic [3:0]  in_slot_i,
  input  logic [3:0]  in_field_bytes_i,
  input  logic [1:0]  in_field_kind_i,
  input  logic [63:0] in_load_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_out_bytes_o,
  output logic [3:0]  out_out_count_o,
  output logic        out_end_of_frame_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_HDR  = 4'b0100,
    ST_CHAN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]  word_size_q;
  logic        count_down_q;
  logic        big_endian_q;
  logic [31:0] step_q;
  logic [4:0]  chan_count_q;
  logic [3:0]  hdr_count_q;

  logic [fcpg_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [fcpg_pkg::LEN_W-1:0] acc_q, acc_d;

  logic        out_valid_q, out_valid_d;
  logic [63:0] out_bytes_q, out_bytes_d;
  logic [3:0]  out_count_q, out_count_d;
  logic        out_eof_q, out_eof_d;
  logic        load_out;

  logic [fcpg_pkg::FIELD_CNT_W-1:0] nf;
  logic [fcpg_pkg::CHAN_CNT_W-1:0]  nc;
  logic [3:0]                       wb;
  logic [fcpg_pkg::IDX_W-1:0]       idx_inc;
  logic                             last_field, last_chan;
  logic                             in_xfer, out_free;
  logic [3:0]                       ld_len;

  fcpg_pkg::hdr_wr_t  hdr_wr;
  fcpg_pkg::chan_wr_t chan_wr;

  logic [3:0]  hdr_len;
  logic [1:0]  hdr_kind;
  logic [63:0] hdr_value;
  logic [63:0] hdr_raw;
  logic [63:0] chan_rd;
  logic [63:0] alu_a, alu_b, alu_sum;
  logic        alu_sub;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_size_q  <= 2'd2;
      count_down_q <= 1'b0;
      big_endian_q <= 1'b0;
      step_q       <= 32'd1;
      chan_count_q <= 5'd1;
      hdr_count_q  <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fcpg_pkg::CFG_WORD_SIZE:  word_size_q  <= cfg_data_i[1:0];
        fcpg_pkg::CFG_COUNT_DOWN: count_down_q <= cfg_data_i[0];
        fcpg_pkg::CFG_BIG_ENDIAN: big_endian_q <= cfg_data_i[0];
        fcpg_pkg::CFG_STEP:       step_q       <= cfg_data_i;
        fcpg_pkg::CFG_CHAN_COUNT: chan_count_q <= cfg_data_i[4:0];
        fcpg_pkg::CFG_HDR_COUNT:  hdr_count_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // clamped frame geometry
  always_comb begin
    if (int'(hdr_count_q) > fcpg_pkg::MAX_FIELDS) begin
      nf = fcpg_pkg::FIELD_CNT_W'(fcpg_pkg::MAX_FIELDS);
    end else begin
      nf = fcpg_pkg::FIELD_CNT_W'(hdr_count_q);
    end
    if (chan_count_q == 5'd0) begin
      nc = fcpg_pkg::CHAN_CNT_W'(1);
    end else if (int'(chan_count_q) > fcpg_pkg::MAX_CHANNELS) begin
      nc = fcpg_pkg::CHAN_CNT_W'(fcpg_pkg::MAX_CHANNELS);
    end else begin
      nc = fcpg_pkg::CHAN_CNT_W'(chan_count_q);
    end
  end

  assign wb         = 4'd1 << word_size_q;
  assign idx_inc    = idx_q + fcpg_pkg::IDX_W'(1);
  assign last_field = (idx_inc == fcpg_pkg::IDX_W'(nf));
  assign last_chan  = (idx_inc == fcpg_pkg::IDX_W'(nc));
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // storage
  always_comb begin
    if (in_field_bytes_i == 4'd0) begin
      ld_len = 4'd1;
    end else if (in_field_bytes_i > 4'd8) begin
      ld_len = 4'd8;
    end else begin
      ld_len = in_field_bytes_i;
    end
  end

  assign hdr_wr.en    = in_xfer && (in_operation_i == fcpg_pkg::OP_LOAD_FIELD) &&
                        (int'(in_slot_i) < fcpg_pkg::MAX_FIELDS);
  assign hdr_wr.idx   = fcpg_pkg::FIELD_IDX_W'(in_slot_i);
  assign hdr_wr.len   = ld_len;
  assign hdr_wr.kind  = in_field_kind_i;
  assign hdr_wr.value = in_load_value_i;

  always_comb begin
    chan_wr.en   = 1'b0;
    chan_wr.idx  = fcpg_pkg::CHAN_IDX_W'(in_slot_i);
    chan_wr.data = in_load_value_i;
    if (state_q == ST_CHAN) begin
      chan_wr.en   = out_free;
      chan_wr.idx  = idx_q[fcpg_pkg::CHAN_IDX_W-1:0];
      chan_wr.data = alu_sum;
    end else if (in_xfer && (in_operation_i == fcpg_pkg::OP_LOAD_CHAN) &&
                 (int'(in_slot_i) < fcpg_pkg::MAX_CHANNELS)) begin
      chan_wr.en = 1'b1;
    end
  end

  fcpg_hdr_table u_hdr_table (
    .clk_i      (clk_i),
    .wr_i       (hdr_wr),
    .rd_idx_i   (idx_q[fcpg_pkg::FIELD_IDX_W-1:0]),
    .rd_len_o   (hdr_len),
    .rd_kind_o  (hdr_kind),
    .rd_value_o (hdr_value)
  );

  fcpg_chan_bank u_chan_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (chan_wr),
    .rd_idx_i  (idx_q[fcpg_pkg::CHAN_IDX_W-1:0]),
    .rd_data_o (chan_rd)
  );

  // shared adder operands
  always_comb begin
    if (state_q == ST_SUM) begin
      alu_a   = 64'(acc_q);
      alu_b   = 64'(hdr_len);
      alu_sub = 1'b0;
    end else begin
      alu_a   = chan_rd;
      alu_b   = {{32{step_q[31]}}, step_q};
      alu_sub = count_down_q;
    end
  end

  fcpg_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  always_comb begin
    case (fcpg_pkg::kind_e'(hdr_kind))
      fcpg_pkg::KIND_SIZE:  hdr_raw = 64'(acc_q);
      fcpg_pkg::KIND_FIXED: hdr_raw = hdr_value;
      default:              hdr_raw = 64'd0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    load_out    = 1'b0;
    out_bytes_d = out_bytes_q;
    out_count_d = out_count_q;
    out_eof_d   = out_eof_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_operation_i == fcpg_pkg::OP_EMIT)) begin
          idx_d   = '0;
          acc_d   = fcpg_pkg::LEN_W'(nc) << word_size_q;
          state_d = (nf == '0) ? ST_CHAN : ST_SUM;
        end
      end
      ST_SUM: begin
        acc_d = alu_sum[fcpg_pkg::LEN_W-1:0];
        if (last_field) begin
          idx_d   = '0;
          state_d = ST_HDR;
        end else begin
          idx_d = idx_inc;
        end
      end
      ST_HDR: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_bytes_d = fcpg_pkg::format_bytes(hdr_raw, hdr_len, big_endian_q);
          out_count_d = hdr_len;
          out_eof_d   = 1'b0;
          if (last_field) begin
            idx_d   = '0;
            state_d = ST_CHAN;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      ST_CHAN: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_bytes_d = fcpg_pkg::format_bytes(chan_rd, wb, big_endian_q);
          out_count_d = wb;
          out_eof_d   = last_chan;
          if (last_chan) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (load_out) begin
      out_bytes_q <= out_bytes_d;
      out_count_q <= out_count_d;
      out_eof_q   <= out_eof_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_out_bytes_o    = out_bytes_q;
  assign out_out_count_o    = out_count_q;
  assign out_end_of_frame_o = out_eof_q;

  // an accepted emit keeps the input side busy, a load does not
  `ASSERT_NEXT(a_emit_busy, in_xfer && (in_operation_i == fcpg_pkg::OP_EMIT), !in_ready_o, "emit transfer did not block input")
  `ASSERT_NEXT(a_load_quick, in_xfer && (in_operation_i != fcpg_pkg::OP_EMIT), in_ready_o, "load transfer blocked input")
  // a result is loaded only into a free output stage
  `ASSERT_CLK(a_out_no_overwrite, !load_out || !out_valid_q || out_ready_i, "pending result overwritten")

endmodule
